/* design/m3h_pkg.sv */
// shared types and constants for the murmur3 32-bit hash stream block
`default_nettype none

package m3h_pkg;

   localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2     = 32'h1b873593;
   localparam logic [31:0] MIX_ADD    = 32'he6546b64;
   localparam logic [31:0] FIN_M1     = 32'h85ebca6b;
   localparam logic [31:0] FIN_M2     = 32'hc2b2ae35;
   localparam logic [31:0] SEED_RESET = 32'h9747b28c;

   localparam logic [2:0] COUNT_FULL = 3'd4;

   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_SEED = 1'b0;

   typedef enum logic [1:0] {
      KIND_FULL,
      KIND_ERROR,
      KIND_LAST
   } kind_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  count;
      kind_type    kind;
   } beat_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

endpackage

`default_nettype wire

/* design/murmur3_32_hash_stream_top.sv */
// top level of the murmur3 32-bit hash stream block with its seed register
`default_nettype none

// Hashes one message at a time with 32-bit MurmurHash3 (x86_32). Push one
// little-endian word per beat with its valid byte count and a last mark; a
// result (hash, or error for a short word that is not last) appears on the
// rsp_ side. A front register takes beats into a four-entry queue, so input
// keeps flowing while the hash engine works or a result waits to be popped.
// The engine is a sequencer with one multiplier step per cycle: a full word
// runs MUL1, MUL2 and FOLD, a last word then FIN1 to FIN3 and EMIT (an empty
// one skips to FIN1), an error beat goes to EMIT, and EMIT waits for a free
// result slot. The seed is taken when the first word of a message reaches
// the engine, so a write lands at the next message start.

module murmur3_32_hash_stream_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic [31:0]                       req_data_word,
   input  wire logic [2:0]                        req_byte_count,
   input  wire logic                              req_last,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [31:0]                            rsp_hash_value,
   output logic                                   rsp_error,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [m3h_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   logic                 seed_wr;
   logic [31:0]          seed_val_ff;
   logic                 q_push, q_full, q_pop, q_empty;
   m3h_pkg::beat_type    push_beat, pop_beat;
   logic                 seed_sel;

   assign csr_pready = 1'b1;
   assign seed_sel   = (csr_paddr[m3h_pkg::CSR_ADDR_W-1] == m3h_pkg::REG_SEED);
   assign csr_prdata = seed_sel ? seed_val_ff : 32'h0;
   assign seed_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready && seed_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_val_ff <= m3h_pkg::SEED_RESET;
      end else if (seed_wr) begin
         seed_val_ff <= csr_pwdata;
      end
   end

   m3h_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .q_push         (q_push),
      .q_beat         (push_beat),
      .q_full         (q_full)
   );

   m3h_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_beat (push_beat),
      .full      (q_full),
      .pop       (q_pop),
      .pop_beat  (pop_beat),
      .empty     (q_empty)
   );

   m3h_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .q_beat         (pop_beat),
      .seed           (seed_val_ff),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hash_value (rsp_hash_value),
      .rsp_error      (rsp_error)
   );

endmodule

`default_nettype wire

/* design/m3h_front.sv */
// input stage: saturates the byte count, masks tail bytes and classifies each beat
`default_nettype none

module m3h_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [31:0]       req_data_word,
   input  wire logic [2:0]        req_byte_count,
   input  wire logic              req_last,
   output logic                   q_push,
   output m3h_pkg::beat_type      q_beat,
   input  wire logic              q_full
);

   logic                 valid_ff, valid_in;
   m3h_pkg::beat_type    beat_ff, beat_in;
   logic                 accept;
   logic [2:0]           count_sat;

   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = valid_ff && !q_full;
   assign q_beat   = beat_ff;

   always_comb begin
      count_sat = (req_byte_count > m3h_pkg::COUNT_FULL) ? m3h_pkg::COUNT_FULL
                                                         : req_byte_count;
      beat_in       = beat_ff;
      valid_in      = valid_ff && q_full;
      if (accept) begin
         valid_in       = 1'b1;
         beat_in.count  = count_sat;
         beat_in.word   = req_data_word;
         if (!req_last) begin
            beat_in.kind = (count_sat == m3h_pkg::COUNT_FULL) ? m3h_pkg::KIND_FULL
                                                              : m3h_pkg::KIND_ERROR;
         end else begin
            beat_in.kind = m3h_pkg::KIND_LAST;
            // bytes above the count are dropped before scrambling
            case (count_sat)
               3'd0:    beat_in.word = 32'h0;
               3'd1:    beat_in.word = {24'h0, req_data_word[7:0]};
               3'd2:    beat_in.word = {16'h0, req_data_word[15:0]};
               3'd3:    beat_in.word = {8'h0, req_data_word[23:0]};
               default: beat_in.word = req_data_word;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

endmodule

`default_nettype wire

/* design/m3h_queue.sv */
// short queue of classified beats between the front stage and the hash engine
`default_nettype none

module m3h_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  m3h_pkg::beat_type      push_beat,
   output logic                   full,
   input  wire logic              pop,
   output m3h_pkg::beat_type      pop_beat,
   output logic                   empty
);

   m3h_pkg::beat_type                  entry_ff [m3h_pkg::QUEUE_DEPTH];
   logic [m3h_pkg::QUEUE_IDX_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [m3h_pkg::QUEUE_IDX_W:0]      fill_ff;
   logic                               do_push, do_pop;

   assign full     = (fill_ff == (m3h_pkg::QUEUE_IDX_W+1)'(m3h_pkg::QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_beat = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

`default_nettype wire

/* design/m3h_back.sv */
// hash engine: word scramble, fold into the running hash, avalanche and result register
`default_nettype none

module m3h_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   output logic                   q_pop,
   input  m3h_pkg::beat_type      q_beat,
   input  wire logic [31:0]       seed,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [31:0]            rsp_hash_value,
   output logic                   rsp_error
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_FOLD,
      S_FIN1,
      S_FIN2,
      S_FIN3,
      S_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic                 at_start_ff, at_start_in;
   logic [31:0]          hash_ff, hash_in;
   logic [31:0]          total_ff, total_in;
   logic [31:0]          k_ff, k_in;
   logic [31:0]          word_ff, word_in;
   logic [2:0]           count_ff, count_in;
   m3h_pkg::kind_type    kind_ff, kind_in;
   logic                 err_ff, err_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_hash_ff, rsp_hash_in;
   logic                 rsp_error_ff, rsp_error_in;

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign rsp_error      = rsp_error_ff;

   always_comb begin
      logic [31:0] base_hash;
      logic [31:0] base_total;
      logic [31:0] mixed;
      logic [31:0] rot;
      logic [31:0] x;

      base_hash    = at_start_ff ? seed : hash_ff;
      base_total   = at_start_ff ? 32'h0 : total_ff;
      mixed        = hash_ff ^ k_ff;
      rot          = {mixed[18:0], mixed[31:19]};
      x            = 32'h0;
      state_in     = state_ff;
      at_start_in  = at_start_ff;
      hash_in      = hash_ff;
      total_in     = total_ff;
      k_in         = k_ff;
      word_in      = word_ff;
      count_in     = count_ff;
      kind_in      = kind_ff;
      err_in       = err_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_hash_in  = rsp_hash_ff;
      rsp_error_in = rsp_error_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop       = 1'b1;
               word_in     = q_beat.word;
               count_in    = q_beat.count;
               kind_in     = q_beat.kind;
               at_start_in = 1'b0;
               hash_in     = base_hash;
               if (q_beat.kind == m3h_pkg::KIND_ERROR) begin
                  total_in = base_total;
                  k_in     = 32'h0;
                  err_in   = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  total_in = base_total + {29'h0, q_beat.count};
                  err_in   = 1'b0;
                  state_in = (q_beat.count == 3'd0) ? S_FIN1 : S_MUL1;
               end
            end
         end
         S_MUL1: begin
            k_in     = word_ff * m3h_pkg::MIX_C1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            k_in     = {k_ff[16:0], k_ff[31:17]} * m3h_pkg::MIX_C2;
            state_in = S_FOLD;
         end
         S_FOLD: begin
            // tail bytes are folded in without the rotate, times five and add
            if (count_ff == m3h_pkg::COUNT_FULL) begin
               hash_in = {rot[29:0], 2'b00} + rot + m3h_pkg::MIX_ADD;
            end else begin
               hash_in = mixed;
            end
            state_in = (kind_ff == m3h_pkg::KIND_LAST) ? S_FIN1 : S_IDLE;
         end
         S_FIN1: begin
            x           = hash_ff ^ total_ff;
            x           = x ^ {16'h0, x[31:16]};
            k_in        = x * m3h_pkg::FIN_M1;
            at_start_in = 1'b1;
            state_in    = S_FIN2;
         end
         S_FIN2: begin
            x        = k_ff ^ {13'h0, k_ff[31:13]};
            k_in     = x * m3h_pkg::FIN_M2;
            state_in = S_FIN3;
         end
         S_FIN3: begin
            k_in     = k_ff ^ {16'h0, k_ff[31:16]};
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = k_ff;
               rsp_error_in = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         at_start_ff  <= 1'b1;
         hash_ff      <= 32'h0;
         total_ff     <= 32'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         at_start_ff  <= at_start_in;
         hash_ff      <= hash_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff         <= k_in;
      word_ff      <= word_in;
      count_ff     <= count_in;
      kind_ff      <= kind_in;
      err_ff       <= err_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_error_ff <= rsp_error_in;
   end

endmodule

`default_nettype wire

/* design/m3h_checker.sv */
// port-level checks for the hash stream top level, bound to it
`default_nettype none

module m3h_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_full,
   input wire logic                              rsp_empty,
   input wire logic                              rsp_pop,
   input wire logic [31:0]                       rsp_hash_value,
   input wire logic                              rsp_error,
   input wire logic                              csr_pready
);

   // nothing waits and input is open right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not clear after reset");

   // an error beat never carries a hash
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error) |-> (rsp_hash_value == 32'h0))
      else $error("error result with nonzero hash");

   // a waiting result holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_hash_value) && $stable(rsp_error)))
      else $error("result changed while stalled");

   // register port never inserts wait states
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready low");

endmodule

bind murmur3_32_hash_stream_top m3h_checker u_m3h_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_hash_value (rsp_hash_value),
   .rsp_error      (rsp_error),
   .csr_pready     (csr_pready)
);

`default_nettype wire

/* tb/murmur3_32_hash_stream_top_tb.sv */
// self-checking testbench for the murmur3 32-bit hash stream top level
module murmur3_32_hash_stream_top_tb;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SETTLE_CYCLES   = 64;
   localparam int ITEMS_PER_PHASE = 570;
   localparam int MAX_REPORTS     = 10;
   localparam int SEED_ADDR       = 4 * m3h_pkg::REG_SEED;

   typedef struct packed {
      logic [31:0] hash;
      logic        err;
   } hash_result_type;

   typedef struct packed {
      bit          set_seed;
      logic [31:0] word;
      logic [2:0]  cnt;
      logic        last;
      bit          typed;
      logic [31:0] hash;
      logic        err;
   } stim_row_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_push       = 1'b0;
   logic        req_full;
   logic [31:0] req_data_word  = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_last       = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop        = 1'b0;
   logic [31:0] rsp_hash_value;
   logic        rsp_error;
   logic        csr_psel       = 1'b0;
   logic        csr_penable    = 1'b0;
   logic        csr_pwrite     = 1'b0;
   logic [m3h_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata     = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   logic [31:0] model_seed  = m3h_pkg::SEED_RESET;
   logic [31:0] model_hash  = '0;
   logic [31:0] model_total = '0;
   bit          model_start = 1'b1;

   hash_result_type expected_q[$];
   stim_row_type    stim_rows[$];
   int              fail_count    = 0;
   int              items_sent    = 0;
   int              idle_cycles   = 0;
   int              send_idle_pct = 28;
   int              recv_idle_pct = 52;

   murmur3_32_hash_stream_top uut (.*);

   always #1 clock = ~clock;

   function automatic logic [31:0] rol32(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic logic [31:0] mix_word(logic [31:0] k);
      k = k * m3h_pkg::MIX_C1;
      k = rol32(k, 15);
      return k * m3h_pkg::MIX_C2;
   endfunction

   function automatic logic [31:0] fold_word(logic [31:0] h, logic [31:0] k);
      h = h ^ mix_word(k);
      return rol32(h, 13) * 5 + m3h_pkg::MIX_ADD;
   endfunction

   function automatic bit predict_hash(input logic [31:0] word, input logic [2:0] cnt,
                                       input logic last, output hash_result_type res);
      logic [2:0]  n;
      logic [31:0] mask;
      logic [31:0] h;
      n = (cnt > m3h_pkg::COUNT_FULL) ? m3h_pkg::COUNT_FULL : cnt;
      res.hash = '0;
      res.err  = 1'b0;
      if (model_start) begin
         model_hash  = model_seed;
         model_total = '0;
         model_start = 1'b0;
      end
      if (!last) begin
         // short word mid-message is dropped, message carries on
         if (n < m3h_pkg::COUNT_FULL) begin
            res.err = 1'b1;
            return 1'b1;
         end
         model_hash  = fold_word(model_hash, word);
         model_total = model_total + 32'd4;
         return 1'b0;
      end
      if (n == m3h_pkg::COUNT_FULL) begin
         model_hash = fold_word(model_hash, word);
      end else if (n != 3'd0) begin
         mask       = (32'h1 << (8 * n)) - 32'h1;
         model_hash = model_hash ^ mix_word(word & mask);
      end
      model_total = model_total + 32'(n);
      h = model_hash ^ model_total;
      h = h ^ (h >> 16);
      h = h * m3h_pkg::FIN_M1;
      h = h ^ (h >> 13);
      h = h * m3h_pkg::FIN_M2;
      h = h ^ (h >> 16);
      res.hash    = h;
      model_start = 1'b1;
      return 1'b1;
   endfunction

   task automatic add_beat(logic [31:0] word, logic [2:0] cnt, logic last);
      stim_rows.push_back('{1'b0, word, cnt, last, 1'b0, 32'h0, 1'b0});
   endtask

   task automatic add_typed(logic [31:0] word, logic [2:0] cnt, logic last,
                            logic [31:0] hash, logic err);
      stim_rows.push_back('{1'b0, word, cnt, last, 1'b1, hash, err});
   endtask

   task automatic add_seed(logic [31:0] value);
      stim_rows.push_back('{1'b1, value, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0});
   endtask

   task automatic send_beat(logic [31:0] word, logic [2:0] cnt, logic last,
                            bit typed, logic [31:0] t_hash, logic t_err);
      hash_result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_data_word  <= word;
      req_byte_count <= cnt;
      req_last       <= last;
      do @(posedge clock); while (req_full);
      items_sent++;
      if (predict_hash(word, cnt, last, res)) begin
         if (typed) begin
            res.hash = t_hash;
            res.err  = t_err;
         end
         expected_q.push_back(res);
      end
   endtask

   // wait for every result, then let any full words still in the engine finish
   task automatic drain_and_settle;
      req_push <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(logic [31:0] value);
      drain_and_settle();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= SEED_ADDR[m3h_pkg::CSR_ADDR_W-1:0];
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      model_seed = value;
   endtask

   task automatic send_message;
      int         n_full;
      logic [2:0] c;
      // occasional stray beat ahead of the message
      if ($urandom_range(0, 19) == 0)
         send_beat($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'b0, 32'h0, 1'b0);
      n_full = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      for (int i = 0; i < n_full; i++) begin
         if ($urandom_range(0, 99) < 8)
            send_beat($urandom, 3'($urandom_range(0, 3)), 1'b0, 1'b0, 32'h0, 1'b0);
         c = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7)) : m3h_pkg::COUNT_FULL;
         send_beat($urandom, c, 1'b0, 1'b0, 32'h0, 1'b0);
      end
      send_beat($urandom, 3'($urandom_range(0, 7)), 1'b1, 1'b0, 32'h0, 1'b0);
   endtask

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_results
      hash_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected result beat: hash %h error %b", rsp_hash_value, rsp_error);
         end else begin
            want = expected_q.pop_front();
            if (rsp_hash_value !== want.hash || rsp_error !== want.err) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("result mismatch: expected hash %h error %b, got hash %h error %b",
                           want.hash, want.err, rsp_hash_value, rsp_error);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("murmur3_32_hash_stream_top: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int start_count;

      // reset seed in force
      add_beat(32'h0000_0000, 3'd0, 1'b1);
      add_beat(32'hffff_ffff, 3'd4, 1'b0);
      add_beat(32'hffff_ffff, 3'd3, 1'b1);
      add_beat(32'h1234_5678, 3'd1, 1'b1);
      add_beat(32'hdead_beef, 3'd2, 1'b1);
      add_beat(32'h0000_0000, 3'd4, 1'b1);
      // short words that are not last, the first of them opening a message
      add_typed(32'ha5a5_a5a5, 3'd0, 1'b0, 32'h0, 1'b1);
      add_typed(32'hffff_ffff, 3'd1, 1'b0, 32'h0, 1'b1);
      add_typed(32'h5a5a_5a5a, 3'd2, 1'b0, 32'h0, 1'b1);
      add_typed(32'hffff_ffff, 3'd3, 1'b0, 32'h0, 1'b1);
      add_beat(32'h6161_6161, 3'd4, 1'b0);
      add_typed(32'h0012_3456, 3'd3, 1'b0, 32'h0, 1'b1);
      add_beat(32'hff63_6261, 3'd3, 1'b1);
      // counts above four saturate
      add_beat(32'hffff_ffff, 3'd5, 1'b0);
      add_beat(32'h8000_0001, 3'd6, 1'b0);
      add_beat(32'h7fff_fffe, 3'd7, 1'b1);
      add_beat(32'h0000_0000, 3'd4, 1'b0);
      add_beat(32'hffff_ffff, 3'd0, 1'b1);
      // zero seed: empty message hashes to zero
      add_seed(32'h0000_0000);
      add_typed(32'hffff_ffff, 3'd0, 1'b1, 32'h0, 1'b0);
      add_beat(32'hffff_ffff, 3'd4, 1'b1);
      add_seed(32'hffff_ffff);
      add_beat(32'h0000_0000, 3'd0, 1'b1);
      add_beat(32'hffff_ffff, 3'd7, 1'b0);
      add_beat(32'hffff_ffff, 3'd1, 1'b1);
      add_typed(32'h0000_0000, 3'd3, 1'b0, 32'h0, 1'b1);
      add_beat(32'h0000_0000, 3'd0, 1'b1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].set_seed)
            write_seed(stim_rows[i].word);
         else
            send_beat(stim_rows[i].word, stim_rows[i].cnt, stim_rows[i].last,
                      stim_rows[i].typed, stim_rows[i].hash, stim_rows[i].err);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 28;
               recv_idle_pct = 52;
            end
            1: begin
               send_idle_pct = 52;
               recv_idle_pct = 28;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_seed($urandom);
         start_count = items_sent;
         while (items_sent - start_count < ITEMS_PER_PHASE) send_message();
      end

      drain_and_settle();
      if (fail_count == 0)
         $display("murmur3_32_hash_stream_top: match");
      else
         $display("murmur3_32_hash_stream_top: mismatch");
      $finish;
   end

endmodule
